[sv/wrms_pkg.sv]
`timescale 1ns / 1ps
// Package for the windowed rms and temperature monitor.
// Holds fixed-point constants and the result type; depends on nothing.
package wrms_pkg;

	// Gain reciprocals in Q7.16, the mid-scale offset in Q12.4.
	localparam int GAIN_W = 23;
	localparam logic [GAIN_W-1:0] VGAIN_Q16 = 23'd7545015;
	localparam logic [GAIN_W-1:0] IGAIN_Q16 = 23'd446127;
	localparam int FRAC_SHIFT = 20;
	localparam logic [15:0] VOFFSET_Q4 = 16'd32959;

	// Temperature is (raw * 10 - 6204) / 124, truncated toward zero.
	localparam logic [15:0] TEMP_RAW_MAX = 16'd1860;
	localparam logic [15:0] TEMP_OFF_X10 = 16'd6204;
	localparam logic [7:0] TEMP_DIV = 8'd124;

	localparam logic [15:0] WINDOW_RESET = 16'd5000;
	localparam logic [47:0] CSUM_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [17:0] VRMS_MAX = 18'h3FFFF;
	localparam logic [13:0] IRMS_MAX = 14'h3FFF;

	localparam int DIV_STEPS = 64;
	localparam int ROOT_STEPS = 32;

	typedef struct packed {
		logic [13:0] line_irms;
		logic [17:0] line_vrms;
		logic [7:0] geyser_temperature;
		logic [7:0] ambient_temperature;
	} result_t;

endpackage

[sv/windowed_rms_and_temperature_monitor.sv]
`timescale 1ns / 1ps
// Per input beat: a bit-serial gain multiply, a bit-serial square, accumulate, output load.
// An item that closes a window also runs the radix-2 divider and then the square root.
// A new item is taken only in the idle state, so the next item waits until the last one
// is through; the output load itself waits until the output register is free.
// Asynchronous reset clears sums, count, held values and sets window_length to 5000.
// Depends on wrms_pkg.
module windowed_rms_and_temperature_monitor #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// voltage_sample, current_sample, ambient_sample, geyser_sample
	input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// ambient_temperature, geyser_temperature, line_vrms, line_irms
	output logic [47:0] m_tdata,
	// rms_ready
	output logic m_tuser
);

	localparam int MAG_W = (SAMPLE_BITS + 4 > 16) ? SAMPLE_BITS + 4 : 16;
	localparam int PROD_W = MAG_W + wrms_pkg::GAIN_W;
	localparam int MW = PROD_W - wrms_pkg::FRAC_SHIFT;
	localparam int SQ_W = 2 * MW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_ROOT = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [6:0] step_q;
	logic [15:0] wlen_q;
	logic [63:0] vsum_q;
	logic [47:0] isum_q;
	logic [15:0] count_q;
	logic [7:0] held_amb_q;
	logic [7:0] held_gey_q;
	logic [17:0] held_vrms_q;
	logic [13:0] held_irms_q;
	logic win_end_q;
	logic m_tvalid_q;
	logic m_tuser_q;
	wrms_pkg::result_t m_tdata_q;

	// Lane 0 is voltage, lane 1 is current; temperature lane 0 is ambient, 1 is geyser.
	logic [PROD_W-1:0] prod_q [2];
	logic [SQ_W-1:0] sq_q [2];
	logic [MW-1:0] mcand_q [2];
	logic [MAG_W-1:0] tdv_q [2];
	logic [6:0] trem_q [2];
	logic tneg_q [2];
	logic tok_q [2];
	logic [63:0] dq_q [2];
	logic [15:0] drem_q [2];
	logic [15:0] dwin_q;
	logic [63:0] sx_q [2];
	logic [31:0] root_q [2];
	logic [33:0] srem_q [2];

	logic [SAMPLE_BITS-1:0] raw [4];
	logic [wrms_pkg::GAIN_W-1:0] gain [2];
	logic [MAG_W-1:0] mag_in [2];
	logic [MAG_W-1:0] tabs_in [2];
	logic tneg_in [2];
	logic tok_in [2];
	logic [PROD_W-1:0] prod_nx [2];
	logic [SQ_W-1:0] sq_nx [2];
	logic [MAG_W-1:0] tdv_nx [2];
	logic [6:0] trem_nx [2];
	logic [63:0] dq_nx [2];
	logic [15:0] drem_nx [2];
	logic [63:0] sx_nx [2];
	logic [31:0] root_nx [2];
	logic [33:0] srem_nx [2];
	logic [7:0] tval [2];

	logic [64:0] vtot;
	logic [48:0] itot;
	logic [63:0] vnew;
	logic [47:0] inew;
	logic [16:0] cnt1;
	logic [15:0] win_eff;
	logic at_end;
	logic [17:0] vrms_sat;
	logic [13:0] irms_sat;
	logic out_free;
	wrms_pkg::result_t res_d;

	always_comb begin
		logic [MAG_W-1:0] q4;
		logic [MAG_W-1:0] x10;
		logic [MAG_W-1:0] off;
		logic [MAG_W-1:0] toff;
		logic [wrms_pkg::GAIN_W:0] psum;
		logic [MW:0] ssum;
		logic [7:0] tr;
		logic tge;
		logic [16:0] dr;
		logic dge;
		logic [35:0] rr;
		logic [35:0] trial;
		logic sge;
		off = MAG_W'(wrms_pkg::VOFFSET_Q4);
		toff = MAG_W'(wrms_pkg::TEMP_OFF_X10);
		gain[0] = wrms_pkg::VGAIN_Q16;
		gain[1] = wrms_pkg::IGAIN_Q16;
		for (int k = 0; k < 4; k++) begin
			raw[k] = s_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
		end
		for (int k = 0; k < 2; k++) begin
			q4 = MAG_W'({raw[k], 4'b0000});
			mag_in[k] = (q4 >= off) ? q4 - off : off - q4;

			x10 = MAG_W'({raw[k+2], 3'b000}) + MAG_W'({raw[k+2], 1'b0});
			tneg_in[k] = x10 < toff;
			tabs_in[k] = tneg_in[k] ? toff - x10 : x10 - toff;
			tok_in[k] = MAG_W'(raw[k+2]) <= MAG_W'(wrms_pkg::TEMP_RAW_MAX);

			// Shift-right multiplier: one multiplier bit retires per cycle.
			psum = {1'b0, prod_q[k][PROD_W-1:MAG_W]}
				+ (prod_q[k][0] ? {1'b0, gain[k]} : '0);
			prod_nx[k] = {psum, prod_q[k][MAG_W-1:1]};

			ssum = {1'b0, sq_q[k][SQ_W-1:MW]} + (sq_q[k][0] ? {1'b0, mcand_q[k]} : '0);
			sq_nx[k] = {ssum, sq_q[k][MW-1:1]};

			tr = {trem_q[k], tdv_q[k][MAG_W-1]};
			tge = tr >= wrms_pkg::TEMP_DIV;
			trem_nx[k] = tge ? 7'(tr - wrms_pkg::TEMP_DIV) : tr[6:0];
			tdv_nx[k] = {tdv_q[k][MAG_W-2:0], tge};

			dr = {drem_q[k], dq_q[k][63]};
			dge = dr >= {1'b0, dwin_q};
			drem_nx[k] = dge ? 16'(dr - {1'b0, dwin_q}) : dr[15:0];
			dq_nx[k] = {dq_q[k][62:0], dge};

			// Digit-by-digit square root, two radicand bits per cycle.
			rr = {srem_q[k], sx_q[k][63:62]};
			trial = {2'b00, root_q[k], 2'b01};
			sge = rr >= trial;
			srem_nx[k] = sge ? 34'(rr - trial) : rr[33:0];
			root_nx[k] = {root_q[k][30:0], sge};
			sx_nx[k] = {sx_q[k][61:0], 2'b00};

			tval[k] = tneg_q[k] ? 8'(8'd0 - tdv_q[k][7:0]) : tdv_q[k][7:0];
		end
	end

	always_comb begin
		vtot = {1'b0, vsum_q} + 65'(sq_q[0]);
		itot = {1'b0, isum_q} + 49'(sq_q[1]);
		vnew = vtot[64] ? '1 : vtot[63:0];
		inew = (itot >= {1'b0, wrms_pkg::CSUM_MAX}) ? wrms_pkg::CSUM_MAX : itot[47:0];
		cnt1 = {1'b0, count_q} + 17'd1;
		win_eff = (wlen_q == 16'd0) ? 16'd1 : wlen_q;
		at_end = cnt1 >= {1'b0, win_eff};
		vrms_sat = (root_q[0] > 32'(wrms_pkg::VRMS_MAX)) ? wrms_pkg::VRMS_MAX
			: root_q[0][17:0];
		irms_sat = (root_q[1] > 32'(wrms_pkg::IRMS_MAX)) ? wrms_pkg::IRMS_MAX
			: root_q[1][13:0];
		out_free = !m_tvalid_q || m_tready;
		res_d.ambient_temperature = held_amb_q;
		res_d.geyser_temperature = held_gey_q;
		res_d.line_vrms = win_end_q ? vrms_sat : held_vrms_q;
		res_d.line_irms = win_end_q ? irms_sat : held_irms_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= 7'd0;
			wlen_q <= wrms_pkg::WINDOW_RESET;
			vsum_q <= 64'd0;
			isum_q <= 48'd0;
			count_q <= 16'd0;
			held_amb_q <= 8'd0;
			held_gey_q <= 8'd0;
			held_vrms_q <= 18'd0;
			held_irms_q <= 14'd0;
			win_end_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				wlen_q <= cfg_data;
			end
			// The finished beat waits in ST_FIN until the output register is free.
			if ((state_q == ST_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= 7'd0;
					if (s_tvalid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == 7'(MAG_W - 1)) begin
						step_q <= 7'd0;
						state_q <= ST_SQR;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_SQR: begin
					if (step_q == 7'(MW - 1)) begin
						step_q <= 7'd0;
						state_q <= ST_ACC;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_ACC: begin
					step_q <= 7'd0;
					if (tok_q[0]) begin
						held_amb_q <= tval[0];
					end
					if (tok_q[1]) begin
						held_gey_q <= tval[1];
					end
					if (at_end) begin
						vsum_q <= 64'd0;
						isum_q <= 48'd0;
						count_q <= 16'd0;
						win_end_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						vsum_q <= vnew;
						isum_q <= inew;
						count_q <= cnt1[15:0];
						win_end_q <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (step_q == 7'(wrms_pkg::DIV_STEPS - 1)) begin
						step_q <= 7'd0;
						state_q <= ST_ROOT;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_ROOT: begin
					if (step_q == 7'(wrms_pkg::ROOT_STEPS - 1)) begin
						step_q <= 7'd0;
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_FIN: begin
					step_q <= 7'd0;
					if (out_free) begin
						if (win_end_q) begin
							held_vrms_q <= vrms_sat;
							held_irms_q <= irms_sat;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					step_q <= 7'd0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					for (int k = 0; k < 2; k++) begin
						prod_q[k] <= PROD_W'(mag_in[k]);
						tdv_q[k] <= tabs_in[k];
						trem_q[k] <= 7'd0;
						tneg_q[k] <= tneg_in[k];
						tok_q[k] <= tok_in[k];
					end
				end
			end
			ST_MUL: begin
				for (int k = 0; k < 2; k++) begin
					prod_q[k] <= prod_nx[k];
					tdv_q[k] <= tdv_nx[k];
					trem_q[k] <= trem_nx[k];
					if (step_q == 7'(MAG_W - 1)) begin
						sq_q[k] <= SQ_W'(prod_nx[k][PROD_W-1:wrms_pkg::FRAC_SHIFT]);
						mcand_q[k] <= prod_nx[k][PROD_W-1:wrms_pkg::FRAC_SHIFT];
					end
				end
			end
			ST_SQR: begin
				for (int k = 0; k < 2; k++) begin
					sq_q[k] <= sq_nx[k];
				end
			end
			ST_ACC: begin
				if (at_end) begin
					dq_q[0] <= vnew;
					dq_q[1] <= 64'(inew);
					drem_q[0] <= 16'd0;
					drem_q[1] <= 16'd0;
					dwin_q <= win_eff;
				end
			end
			ST_DIV: begin
				for (int k = 0; k < 2; k++) begin
					dq_q[k] <= dq_nx[k];
					drem_q[k] <= drem_nx[k];
					if (step_q == 7'(wrms_pkg::DIV_STEPS - 1)) begin
						sx_q[k] <= dq_nx[k];
						root_q[k] <= 32'd0;
						srem_q[k] <= 34'd0;
					end
				end
			end
			ST_ROOT: begin
				for (int k = 0; k < 2; k++) begin
					sx_q[k] <= sx_nx[k];
					root_q[k] <= root_nx[k];
					srem_q[k] <= srem_nx[k];
				end
			end
			ST_FIN: begin
				if (out_free) begin
					m_tdata_q <= res_d;
					m_tuser_q <= win_end_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule
